### design/derb_pkg.sv
`timescale 1ns / 1ps

package derb_pkg;

	localparam int unsigned CountWidth = 5;

	localparam logic [1:0] FUNC_PUSH_TAIL  = 2'd0;
	localparam logic [1:0] FUNC_PUSH_FRONT = 2'd1;
	localparam logic [1:0] FUNC_POP_BACK   = 2'd2;
	localparam logic [1:0] FUNC_POP_FRONT  = 2'd3;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_UNDERFLOW = 2'd1;
	localparam logic [1:0] STATUS_OVERWRITE = 2'd2;

	localparam logic [CountWidth-1:0] CAPACITY_RESET = 5'd16;

	typedef struct packed {
		logic                  load;
		logic [1:0]            func;
		logic                  full;
		logic                  empty;
		logic [CountWidth-1:0] count;
		logic [CountWidth-1:0] cap;
	} derb_ctrl_t;

endpackage

### design/derb_cell.sv
`timescale 1ns / 1ps

module derb_cell #(
	parameter int unsigned DATA_WIDTH = 32,
	parameter int unsigned INDEX      = 0
) (
	input  logic                   clk,
	input  derb_pkg::derb_ctrl_t   ctrl,
	input  logic [DATA_WIDTH-1:0]  push_data,
	input  logic [DATA_WIDTH-1:0]  left_data,
	input  logic [DATA_WIDTH-1:0]  right_data,
	output logic [DATA_WIDTH-1:0]  data_q,
	output logic [DATA_WIDTH-1:0]  data_d
);
	import derb_pkg::*;

	logic at_count;
	logic at_last;

	assign at_count = (32'(ctrl.count) == INDEX);
	assign at_last  = ((32'(ctrl.cap) - 32'd1) == INDEX);

	always_comb begin
		data_d = data_q;
		if (ctrl.load) begin
			unique case (ctrl.func)
				FUNC_PUSH_TAIL: begin
					if (ctrl.full) begin
						data_d = at_last ? push_data : right_data;
					end else if (at_count) begin
						data_d = push_data;
					end
				end
				FUNC_PUSH_FRONT: begin
					data_d = (INDEX == 0) ? push_data : left_data;
				end
				FUNC_POP_BACK: begin
					data_d = data_q;
				end
				FUNC_POP_FRONT: begin
					if (!ctrl.empty) begin
						data_d = right_data;
					end
				end
				default: begin
					data_d = data_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

endmodule

### design/derb_ctrl.sv
`timescale 1ns / 1ps

module derb_ctrl #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           func,
	input  logic                                 out_stall,
	output logic                                 out_valid,
	input  logic                                 cfg_wr_en,
	input  logic [derb_pkg::CountWidth-1:0]      cfg_wr_data,
	input  logic [31:0]                          front_d,
	input  logic [31:0]                          back_d,
	output derb_pkg::derb_ctrl_t                 ctrl,
	output logic [derb_pkg::CountWidth-1:0]      count_next,
	output logic [31:0]                          front_value,
	output logic [31:0]                          back_value,
	output logic [derb_pkg::CountWidth-1:0]      fill_count,
	output logic                                 is_empty,
	output logic                                 is_full,
	output logic [1:0]                           status
);
	import derb_pkg::*;

	logic [CountWidth-1:0] cap_q;
	logic [CountWidth-1:0] count_q;
	logic [CountWidth-1:0] cap_min;
	logic [CountWidth-1:0] cap_eff;
	logic                  out_valid_q;
	logic [31:0]           front_q;
	logic [31:0]           back_q;
	logic [CountWidth-1:0] fill_q;
	logic                  empty_q;
	logic                  full_q;
	logic [1:0]            status_q;
	logic                  accept;
	logic                  full;
	logic                  empty;
	logic [1:0]            status_d;

	assign cap_min  = (cap_q == '0) ? CountWidth'(1) : cap_q;
	assign cap_eff  = (32'(cap_min) > DEPTH) ? CountWidth'(DEPTH) : cap_min;
	assign full     = (count_q == cap_eff);
	assign empty    = (count_q == '0);
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		count_next = count_q;
		status_d   = STATUS_OK;
		unique case (func)
			FUNC_PUSH_TAIL, FUNC_PUSH_FRONT: begin
				if (full) begin
					status_d = STATUS_OVERWRITE;
				end else begin
					count_next = count_q + CountWidth'(1);
				end
			end
			FUNC_POP_BACK, FUNC_POP_FRONT: begin
				if (empty) begin
					status_d = STATUS_UNDERFLOW;
				end else begin
					count_next = count_q - CountWidth'(1);
				end
			end
			default: begin
				count_next = count_q;
			end
		endcase
	end

	always_comb begin
		ctrl.load  = accept;
		ctrl.func  = func;
		ctrl.full  = full;
		ctrl.empty = empty;
		ctrl.count = count_q;
		ctrl.cap   = cap_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAPACITY_RESET;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cap_q   <= cfg_wr_data;
				count_q <= '0;
			end else if (accept) begin
				count_q <= count_next;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			front_q  <= front_d;
			back_q   <= back_d;
			fill_q   <= count_next;
			empty_q  <= (count_next == '0);
			full_q   <= (count_next == cap_eff);
			status_q <= status_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign front_value = front_q;
	assign back_value  = back_q;
	assign fill_count  = fill_q;
	assign is_empty    = empty_q;
	assign is_full     = full_q;
	assign status      = status_q;

`ifndef SYNTHESIS
	a_count_in_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cap_eff)
		else $error("element count exceeds capacity");

	a_result_follows_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted operation produced no result");

	a_empty_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (empty_q == (fill_q == '0)))
		else $error("empty flag disagrees with fill count");

	a_underflow_only_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == STATUS_UNDERFLOW) |-> (empty_q && !full_q))
		else $error("underflow reported on a buffer that is not empty");
`endif

endmodule

### design/double_ended_ring_buffer.sv
`timescale 1ns / 1ps

// Channel   Handshake               Payload
// input     in_valid / in_stall     func, push_value
// output    out_valid / out_stall   front_value, back_value, fill_count, is_empty,
//                                   is_full, status
// config    cfg_wr_en               cfg_wr_data (capacity)
//
// One operation is taken per cycle while not stalled; each cell shifts, loads or holds.
// The result appears in the output register in the cycle after the transfer.
// While a result waits under out_stall, in_stall is high and the chain holds.
// After reset the count is zero, capacity is 16 and cell contents are undefined.

module double_ended_ring_buffer #(
	parameter int unsigned DEPTH      = 16,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        func,
	input  logic [31:0]                       push_value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [31:0]                       front_value,
	output logic [31:0]                       back_value,
	output logic [derb_pkg::CountWidth-1:0]   fill_count,
	output logic                              is_empty,
	output logic                              is_full,
	output logic [1:0]                        status,
	input  logic                              cfg_wr_en,
	input  logic [derb_pkg::CountWidth-1:0]   cfg_wr_data
);
	import derb_pkg::*;

	localparam int unsigned IndexWidth = $clog2(DEPTH);

	derb_ctrl_t            ctrl;
	logic [CountWidth-1:0] count_next;
	logic [DATA_WIDTH-1:0] cell_q [DEPTH];
	logic [DATA_WIDTH-1:0] cell_d [DEPTH];
	logic [63:0]           push_w;
	logic [DATA_WIDTH-1:0] push_data;
	logic [31:0]           back_pos;
	logic [IndexWidth-1:0] back_idx;
	logic [63:0]           front_w;
	logic [63:0]           back_w;
	logic [31:0]           front_d;
	logic [31:0]           back_d;

	assign push_w    = 64'(push_value);
	assign push_data = push_w[DATA_WIDTH-1:0];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_data;
		logic [DATA_WIDTH-1:0] right_data;

		if (i == 0) begin : g_first
			assign left_data = cell_q[i];
		end else begin : g_mid
			assign left_data = cell_q[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_data = cell_q[i];
		end else begin : g_inner
			assign right_data = cell_q[i+1];
		end

		derb_cell #(
			.DATA_WIDTH(DATA_WIDTH),
			.INDEX     (i)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.push_data (push_data),
			.left_data (left_data),
			.right_data(right_data),
			.data_q    (cell_q[i]),
			.data_d    (cell_d[i])
		);
	end

	assign back_pos = 32'(count_next) - 32'd1;
	assign back_idx = back_pos[IndexWidth-1:0];
	assign front_w  = 64'(cell_d[0]);
	assign back_w   = 64'(cell_d[back_idx]);
	assign front_d  = (count_next == '0) ? 32'd0 : front_w[31:0];
	assign back_d   = (count_next == '0) ? 32'd0 : back_w[31:0];

	derb_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.front_d    (front_d),
		.back_d     (back_d),
		.ctrl       (ctrl),
		.count_next (count_next),
		.front_value(front_value),
		.back_value (back_value),
		.fill_count (fill_count),
		.is_empty   (is_empty),
		.is_full    (is_full),
		.status     (status)
	);

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	import derb_pkg::*;

	localparam int unsigned RING_SLOTS  = 16;
	localparam int unsigned SLOT_BITS   = $clog2(RING_SLOTS);
	localparam int unsigned CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [31:0]           front;
		logic [31:0]           back;
		logic [CountWidth-1:0] fill;
		logic                  empty;
		logic                  full;
		logic [1:0]            status;
	} deque_view_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [1:0]            func = FUNC_PUSH_TAIL;
	logic [31:0]           push_value = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [31:0]           front_value;
	logic [31:0]           back_value;
	logic [CountWidth-1:0] fill_count;
	logic                  is_empty;
	logic                  is_full;
	logic [1:0]            status;
	logic                  cfg_wr_en = 1'b0;
	logic [CountWidth-1:0] cfg_wr_data = '0;

	logic [31:0]           ring_mem [RING_SLOTS];
	int unsigned           ring_head = 0;
	int unsigned           ring_count = 0;
	logic [CountWidth-1:0] ring_capacity = CAPACITY_RESET;
	deque_view_t           pending_views [$];

	int unsigned cycle_count = 0;
	int unsigned mismatch_count = 0;
	int          hold_cycles = 0;
	bit          no_idle = 1'b0;

	double_ended_ring_buffer u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.push_value  (push_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.front_value (front_value),
		.back_value  (back_value),
		.fill_count  (fill_count),
		.is_empty    (is_empty),
		.is_full     (is_full),
		.status      (status),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic int unsigned usable_capacity();
		int unsigned c;
		c = 32'(ring_capacity);
		if (c == 0) c = 1;
		if (c > RING_SLOTS) c = RING_SLOTS;
		return c;
	endfunction

	function automatic void apply_capacity(input logic [CountWidth-1:0] value);
		ring_capacity = value;
		ring_head = 0;
		ring_count = 0;
	endfunction

	function automatic void predict_op(input logic [1:0] op, input logic [31:0] value);
		int unsigned cap;
		bit          was_full;
		bit          was_empty;
		deque_view_t view;
		cap = usable_capacity();
		ring_head = ring_head % cap;
		if (ring_count > cap) ring_count = cap;
		was_full = (ring_count == cap);
		was_empty = (ring_count == 0);
		view.status = STATUS_OK;
		case (op)
			FUNC_PUSH_TAIL: begin
				ring_mem[SLOT_BITS'((ring_head + ring_count) % cap)] = value;
				if (was_full) begin
					ring_head = (ring_head + 1) % cap;
					view.status = STATUS_OVERWRITE;
				end else begin
					ring_count++;
				end
			end
			FUNC_PUSH_FRONT: begin
				ring_head = (ring_head + cap - 1) % cap;
				ring_mem[SLOT_BITS'(ring_head)] = value;
				if (was_full) view.status = STATUS_OVERWRITE;
				else ring_count++;
			end
			FUNC_POP_BACK: begin
				if (was_empty) view.status = STATUS_UNDERFLOW;
				else ring_count--;
			end
			default: begin
				if (was_empty) begin
					view.status = STATUS_UNDERFLOW;
				end else begin
					ring_head = (ring_head + 1) % cap;
					ring_count--;
				end
			end
		endcase
		if (ring_count == 0) begin
			view.front = '0;
			view.back = '0;
		end else begin
			view.front = ring_mem[SLOT_BITS'(ring_head)];
			view.back = ring_mem[SLOT_BITS'((ring_head + ring_count - 1) % cap)];
		end
		view.fill = ring_count[CountWidth-1:0];
		view.empty = (ring_count == 0);
		view.full = (ring_count == cap);
		pending_views.insert(pending_views.size(), view);
	endfunction

	function automatic void check_result(input deque_view_t want);
		if (front_value !== want.front) begin
			$error("front_value: expected %h, got %h", want.front, front_value);
			mismatch_count++;
		end
		if (back_value !== want.back) begin
			$error("back_value: expected %h, got %h", want.back, back_value);
			mismatch_count++;
		end
		if (fill_count !== want.fill) begin
			$error("fill_count: expected %0d, got %0d", want.fill, fill_count);
			mismatch_count++;
		end
		if (is_empty !== want.empty) begin
			$error("is_empty: expected %b, got %b", want.empty, is_empty);
			mismatch_count++;
		end
		if (is_full !== want.full) begin
			$error("is_full: expected %b, got %b", want.full, is_full);
			mismatch_count++;
		end
		if (status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, status);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wr_en) apply_capacity(cfg_wr_data);
			if (in_valid && !in_stall) predict_op(func, push_value);
			if (out_valid && !out_stall) begin
				if (pending_views.size() == 0) begin
					$error("result transfer with no expected result pending");
					mismatch_count++;
				end else begin
					check_result(pending_views.pop_front());
				end
			end
		end
	end

	function automatic int draw_gap();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 3);
		if (r == 0) return $urandom_range(0, 16);
		if (r == 1) return $urandom_range(0, 2);
		return 0;
	endfunction

	// The receiver may stall for a drawn gap before each transfer; a hold request overrides one draw.
	initial begin
		int n;
		@(posedge clk);
		forever begin
			if (hold_cycles > 0) begin
				n = hold_cycles;
				hold_cycles = 0;
			end else begin
				n = draw_gap();
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	task automatic send_op(input logic [1:0] op, input logic [31:0] value);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= op;
		push_value <= value;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_random_op(input int push_pct);
		logic [1:0] op;
		if ($urandom_range(0, 99) < push_pct)
			op = $urandom_range(0, 1) ? FUNC_PUSH_TAIL : FUNC_PUSH_FRONT;
		else
			op = $urandom_range(0, 1) ? FUNC_POP_BACK : FUNC_POP_FRONT;
		send_op(op, $urandom());
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_views.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CountWidth-1:0] value);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic test_empty_pops();
		send_op(FUNC_POP_BACK, 32'hFFFF_FFFF);
		send_op(FUNC_POP_FRONT, 32'h0000_0000);
		wait_idle();
	endtask

	task automatic test_push_pop_extremes();
		send_op(FUNC_PUSH_TAIL, 32'h0000_0000);
		send_op(FUNC_PUSH_TAIL, 32'hFFFF_FFFF);
		send_op(FUNC_PUSH_FRONT, 32'hAAAA_AAAA);
		send_op(FUNC_PUSH_FRONT, 32'h5555_5555);
		send_op(FUNC_POP_BACK, 32'h0);
		send_op(FUNC_POP_FRONT, 32'h0);
		send_op(FUNC_POP_BACK, 32'h0);
		send_op(FUNC_POP_FRONT, 32'h0);
		send_op(FUNC_POP_FRONT, 32'h0);
		wait_idle();
	endtask

	// With two slots, a push at either end of a full buffer overwrites the opposite end.
	task automatic test_overwrite_small();
		write_capacity(5'd2);
		send_op(FUNC_PUSH_TAIL, 32'h1111_0001);
		send_op(FUNC_PUSH_TAIL, 32'h2222_0002);
		send_op(FUNC_PUSH_TAIL, 32'h3333_0003);
		send_op(FUNC_PUSH_FRONT, 32'h4444_0004);
		send_op(FUNC_POP_FRONT, 32'h0);
		send_op(FUNC_POP_BACK, 32'h0);
		send_op(FUNC_POP_BACK, 32'h0);
		wait_idle();
	endtask

	// A zero capacity acts as one slot and a capacity above the ring size acts as the ring size.
	task automatic test_capacity_edges();
		write_capacity(5'd0);
		send_op(FUNC_PUSH_TAIL, $urandom());
		send_op(FUNC_PUSH_FRONT, $urandom());
		send_op(FUNC_POP_FRONT, 32'h0);
		write_capacity(5'd31);
		send_op(FUNC_PUSH_FRONT, $urandom());
		send_op(FUNC_PUSH_FRONT, $urandom());
		send_op(FUNC_POP_BACK, 32'h0);
		wait_idle();
	endtask

	// The receiver holds off while the sender keeps offering, so the input side stalls.
	task automatic test_backpressure();
		write_capacity(5'd16);
		hold_cycles = 150;
		no_idle = 1'b1;
		for (int i = 0; i < 30; i++) send_random_op(70);
		no_idle = 1'b0;
		wait_idle();
	endtask

	// Each phase sets a capacity, then sends push-heavy traffic to fill the buffer and pop-heavy traffic to drain it.
	task automatic test_random_phases();
		logic [CountWidth-1:0] caps [8];
		caps = '{5'd1, 5'd3, 5'd16, 5'd5, 5'd2, 5'd31, 5'd0, 5'd16};
		for (int p = 0; p < 8; p++) begin
			if (p == 7) write_capacity(CountWidth'($urandom_range(0, 31)));
			else write_capacity(caps[p]);
			no_idle = (p % 3 == 2);
			for (int i = 0; i < 60; i++) begin
				if (i == 40) no_idle = !no_idle;
				send_random_op((i < 30) ? 80 : 25);
			end
			no_idle = 1'b0;
		end
		wait_idle();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_pops();
		test_push_pop_extremes();
		test_overwrite_small();
		test_capacity_edges();
		test_backpressure();
		test_random_phases();
		wait_idle();
		if (mismatch_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

### double_ended_ring_buffer.f
design/derb_pkg.sv
design/derb_cell.sv
design/derb_ctrl.sv
design/double_ended_ring_buffer.sv
verif/tb_top.sv
